/* rtl/swm_pkg.sv */
package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int LEN_CFG_W = 7;
	localparam int OUT_BITS  = 33;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [LEN_CFG_W-1:0] WINDOW_LENGTH_RST = LEN_CFG_W'(1);

	typedef enum logic {
		REG_WINDOW_LENGTH = 1'b0,
		REG_UNUSED        = 1'b1
	} swm_reg_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic evict;
	} swm_ctl_t;

endpackage

/* rtl/swm_stream_if.sv */
interface swm_sample_if #(
	parameter int W = swm_pkg::SAMPLE_BITS_DEF
);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
	parameter int W = swm_pkg::OUT_BITS
);
	logic         valid;
	logic         ready;
	logic [W-1:0] median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink (input valid, input median_doubled, output ready);
endinterface

/* rtl/swm_cfg.sv */
module swm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]   paddr,
	input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
	output logic [swm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [swm_pkg::LEN_CFG_W-1:0] window_length,
	output logic                          cfg_wr
);

	logic [swm_pkg::LEN_CFG_W-1:0] len_q;
	swm_pkg::swm_reg_t             reg_sel;

	assign reg_sel = swm_pkg::swm_reg_t'(paddr[2]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (reg_sel == swm_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swm_pkg::WINDOW_LENGTH_RST;
		end else if (cfg_wr) begin
			len_q <= pwdata[swm_pkg::LEN_CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			swm_pkg::REG_WINDOW_LENGTH: prdata = swm_pkg::PDATA_W'(len_q);
			default:                    prdata = '0;
		endcase
	end

	assign window_length = len_q;

endmodule

/* rtl/swm_cell.sv */
module swm_cell #(
	parameter int SB    = swm_pkg::SAMPLE_BITS_DEF,
	parameter int AGE_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swm_pkg::swm_ctl_t ctl,
	input  logic [AGE_W-1:0] oldest,
	input  logic [SB-1:0]    s,
	input  logic [SB-1:0]    nxt_val,
	input  logic [AGE_W-1:0] nxt_age,
	input  logic             nxt_vld,
	input  logic             nxt_g,
	input  logic [SB-1:0]    prv_val,
	input  logic [AGE_W-1:0] prv_age,
	input  logic             prv_vld,
	input  logic             prv_rg,
	input  logic             rm_in,
	output logic [SB-1:0]    val,
	output logic [AGE_W-1:0] age,
	output logic             vld,
	output logic             g,
	output logic [SB-1:0]    rv_val,
	output logic [AGE_W-1:0] rv_age,
	output logic             rv_vld,
	output logic             rg,
	output logic             rm_out
);

	logic [SB-1:0]    val_q;
	logic [AGE_W-1:0] age_q;
	logic             vld_q;
	logic             del;

	// Greater-than against the incoming sample; an empty cell counts as greater.
	assign g      = !vld_q || ($signed(val_q) > $signed(s));
	assign del    = ctl.evict && vld_q && (age_q == oldest);
	assign rm_out = rm_in || del;

	// View of this position once the evicted entry has closed its gap.
	assign rv_val = rm_out ? nxt_val : val_q;
	assign rv_age = rm_out ? nxt_age : age_q;
	assign rv_vld = rm_out ? nxt_vld : vld_q;
	assign rg     = rm_out ? nxt_g   : g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.step) begin
			priority if (!rg) begin
				vld_q <= rv_vld;
			end else if (!prv_rg) begin
				vld_q <= 1'b1;
			end else begin
				vld_q <= prv_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			priority if (!rg) begin
				val_q <= rv_val;
				age_q <= rv_age + AGE_W'(1);
			end else if (!prv_rg) begin
				val_q <= s;
				age_q <= '0;
			end else begin
				val_q <= prv_val;
				age_q <= prv_age + AGE_W'(1);
			end
		end
	end

	assign val = val_q;
	assign age = age_q;
	assign vld = vld_q;

endmodule

/* rtl/sliding_window_median.sv */
// Channel  | Direction | Payload                   | Beat accepted when
// samples  | in        | sample [SAMPLE_BITS]      | valid and ready high
// medians  | out       | median_doubled [33]       | valid and ready high
// APB      | in        | window_length at addr 0   | psel, penable, pwrite
//
// One sample is taken every cycle unless a held output stalls it; the sorted
// row of cells inserts the new one at the sample's beat and, once full, evicts
// the oldest entry; the output register then loads the median from the cells.
// Reset and a write of window_length empty the row; no clearing pass is needed.
// A held output stalls the pending result and therefore the sample input.
module sliding_window_median #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	swm_sample_if.sink                  samples,
	swm_median_if.source                medians,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swm_pkg::PADDR_W-1:0] paddr,
	input  logic [swm_pkg::PDATA_W-1:0] pwdata,
	output logic [swm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SEL_W = $clog2(WINDOW_MAX + 1);
	localparam int LEN_W = $clog2(WINDOW_MAX + 1) + 1;
	localparam int OB    = swm_pkg::OUT_BITS;

	logic [swm_pkg::LEN_CFG_W-1:0] len_cfg;
	logic                          cfg_wr;
	logic [LEN_W-1:0]              eff_len;
	logic [LEN_W-1:0]              n_q;
	logic                          full;
	logic                          accept;
	logic                          makes_result;
	logic                          pend_q;
	logic                          out_vld_q;
	logic                          out_load;
	logic [OB-1:0]                 out_q;
	logic [IDX_W-1:0]              oldest;
	logic [SEL_W-1:0]              lo_idx;
	logic [SEL_W-1:0]              hi_idx;
	swm_pkg::swm_ctl_t             ctl;

	logic [SAMPLE_BITS-1:0] c_val  [WINDOW_MAX+1];
	logic [IDX_W-1:0]       c_age  [WINDOW_MAX+1];
	logic                   c_vld  [WINDOW_MAX+1];
	logic                   c_g    [WINDOW_MAX+1];
	logic [SAMPLE_BITS-1:0] r_val  [WINDOW_MAX];
	logic [IDX_W-1:0]       r_age  [WINDOW_MAX];
	logic                   r_vld  [WINDOW_MAX];
	logic                   r_g    [WINDOW_MAX];
	logic                   rm     [WINDOW_MAX+1];

	swm_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.window_length (len_cfg),
		.cfg_wr        (cfg_wr)
	);

	always_comb begin
		priority if (len_cfg == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(len_cfg) > WINDOW_MAX) begin
			eff_len = LEN_W'(WINDOW_MAX);
		end else begin
			eff_len = LEN_W'(len_cfg);
		end
	end

	assign full         = (n_q == eff_len);
	assign makes_result = full || ((n_q + LEN_W'(1)) == eff_len);
	assign out_load     = pend_q && (!out_vld_q || medians.ready);
	assign samples.ready = !pend_q || out_load;
	assign accept       = samples.valid && samples.ready;

	assign oldest = IDX_W'(eff_len - LEN_W'(1));
	assign lo_idx = SEL_W'((eff_len - LEN_W'(1)) >> 1);
	assign hi_idx = SEL_W'(eff_len >> 1);

	assign ctl.step  = accept;
	assign ctl.clear = cfg_wr;
	assign ctl.evict = full;

	assign rm[0]              = 1'b0;
	assign c_val[WINDOW_MAX]  = '0;
	assign c_age[WINDOW_MAX]  = '0;
	assign c_vld[WINDOW_MAX]  = 1'b0;
	assign c_g[WINDOW_MAX]    = 1'b1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] pv;
		logic [IDX_W-1:0]       pa;
		logic                   pvl;
		logic                   pg;

		if (i == 0) begin : g_head
			assign pv  = '0;
			assign pa  = '0;
			assign pvl = 1'b0;
			assign pg  = 1'b0;
		end else begin : g_body
			assign pv  = r_val[i-1];
			assign pa  = r_age[i-1];
			assign pvl = r_vld[i-1];
			assign pg  = r_g[i-1];
		end

		swm_cell #(
			.SB    (SAMPLE_BITS),
			.AGE_W (IDX_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.oldest  (oldest),
			.s       (samples.sample),
			.nxt_val (c_val[i+1]),
			.nxt_age (c_age[i+1]),
			.nxt_vld (c_vld[i+1]),
			.nxt_g   (c_g[i+1]),
			.prv_val (pv),
			.prv_age (pa),
			.prv_vld (pvl),
			.prv_rg  (pg),
			.rm_in   (rm[i]),
			.val     (c_val[i]),
			.age     (c_age[i]),
			.vld     (c_vld[i]),
			.g       (c_g[i]),
			.rv_val  (r_val[i]),
			.rv_age  (r_age[i]),
			.rv_vld  (r_vld[i]),
			.rg      (r_g[i]),
			.rm_out  (rm[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				n_q <= '0;
			end else if (accept && !full) begin
				n_q <= n_q + LEN_W'(1);
			end
			if (cfg_wr) begin
				pend_q <= 1'b0;
			end else if (accept) begin
				pend_q <= makes_result;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (medians.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= OB'($signed(c_val[lo_idx])) + OB'($signed(c_val[hi_idx]));
		end
	end

	assign medians.valid          = out_vld_q;
	assign medians.median_doubled = out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= eff_len)
		else $error("fill count exceeds window length");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (n_q == '0) && !pend_q)
		else $error("configuration write did not empty the window");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && makes_result && !cfg_wr |=> pend_q)
		else $error("sample on a full window left no pending result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && out_vld_q && !medians.ready |-> !samples.ready)
		else $error("sample taken while a result is blocked");
`endif

endmodule

/* verif/swm_median_checker.sv */
`timescale 1ns / 1ps

module swm_median_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	input  logic                                sample_ready,
	input  logic [swm_pkg::SAMPLE_BITS_DEF-1:0] sample,
	input  logic                                median_valid,
	input  logic                                median_ready,
	input  logic [swm_pkg::OUT_BITS-1:0]        median_doubled,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [swm_pkg::PADDR_W-1:0]         paddr,
	input  logic [swm_pkg::PDATA_W-1:0]         pwdata,
	input  logic [swm_pkg::PDATA_W-1:0]         prdata,
	output int                                  pending,
	output int                                  fail_count
);

	localparam int DEPTH = swm_pkg::WINDOW_MAX_DEF;
	localparam int SB    = swm_pkg::SAMPLE_BITS_DEF;
	localparam int OBW   = swm_pkg::OUT_BITS;

	logic signed [SB-1:0]            ring [DEPTH];
	logic signed [SB-1:0]            ordered [DEPTH];
	int unsigned                     held;
	int unsigned                     oldest;
	logic [swm_pkg::LEN_CFG_W-1:0]   win_len;
	logic [OBW-1:0]                  expected_medians [$];
	logic [OBW-1:0]                  want;
	swm_pkg::swm_reg_t               reg_sel;

	function automatic void sorted_put(input int unsigned n,
		input logic signed [SB-1:0] v);
		int unsigned pos;
		int unsigned k;
		pos = 0;
		while (pos < n && ordered[pos] <= v)
			pos++;
		for (k = n; k > pos; k--)
			ordered[k] = ordered[k-1];
		ordered[pos] = v;
	endfunction

	function automatic void sorted_drop(input int unsigned n,
		input logic signed [SB-1:0] v);
		int unsigned pos;
		int unsigned k;
		pos = 0;
		while (pos < n && ordered[pos] != v)
			pos++;
		if (pos >= n)
			return;
		for (k = pos; k + 1 < n; k++)
			ordered[k] = ordered[k+1];
	endfunction

	function automatic void advance_window(input logic signed [SB-1:0] s);
		int unsigned           span;
		int unsigned           slot;
		logic signed [SB-1:0]  leaving;
		logic signed [OBW-1:0] lo;
		logic signed [OBW-1:0] hi;
		span = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : win_len);
		if (held > span) begin
			held = 0;
			oldest = 0;
		end
		if (held < span) begin
			ring[held] = s;
			sorted_put(held, s);
			held++;
			if (held < span)
				return;
		end else begin
			slot = (oldest >= span) ? 0 : oldest;
			leaving = ring[slot];
			ring[slot] = s;
			sorted_drop(span, leaving);
			sorted_put(span - 1, s);
			slot++;
			oldest = (slot >= span) ? 0 : slot;
		end
		// For an odd window both picks land on the middle entry.
		lo = ordered[(span - 1) / 2];
		hi = ordered[span / 2];
		expected_medians.insert(expected_medians.size(), lo + hi);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			oldest = 0;
			win_len = swm_pkg::WINDOW_LENGTH_RST;
			expected_medians.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			reg_sel = swm_pkg::swm_reg_t'(paddr[swm_pkg::PADDR_W-1]);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (reg_sel == swm_pkg::REG_WINDOW_LENGTH) begin
						win_len = pwdata[swm_pkg::LEN_CFG_W-1:0];
						held = 0;
						oldest = 0;
					end
				end else if (reg_sel == swm_pkg::REG_WINDOW_LENGTH &&
					prdata !== swm_pkg::PDATA_W'(win_len)) begin
					$error("window_length: expected %0d, actual %0d", win_len, prdata);
					fail_count++;
				end
			end
			if (sample_valid && sample_ready)
				advance_window(sample);
			if (median_valid && median_ready) begin
				if (expected_medians.size() == 0) begin
					$error("median_doubled: expected none, actual %0d",
						$signed(median_doubled));
					fail_count++;
				end else begin
					want = expected_medians.pop_front();
					if (median_doubled !== want) begin
						$error("median_doubled: expected %0d, actual %0d",
							$signed(want), $signed(median_doubled));
						fail_count++;
					end
				end
			end
			pending <= expected_medians.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int HOLD_CYCLES   = 240;
	localparam int SB            = swm_pkg::SAMPLE_BITS_DEF;
	localparam int LCW           = swm_pkg::LEN_CFG_W;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [swm_pkg::PADDR_W-1:0] paddr;
	logic [swm_pkg::PDATA_W-1:0] pwdata;
	logic [swm_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	int                          pending;
	int                          fail_count;
	bit                          steady = 1'b0;
	int                          hold_requests = 0;
	int                          holds_done = 0;

	swm_sample_if sample_ch ();
	swm_median_if median_ch ();

	sliding_window_median dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.medians (median_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	swm_median_checker median_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_ch.valid),
		.sample_ready   (sample_ch.ready),
		.sample         (sample_ch.sample),
		.median_valid   (median_ch.valid),
		.median_ready   (median_ch.ready),
		.median_doubled (median_ch.median_doubled),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pending        (pending),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		median_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				median_ch.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				median_ch.ready <= 1'b1;
			end else begin
				median_ch.ready <= ($urandom_range(99) >= 28);
			end
		end
	end

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3, 4: return SB'(int'($urandom_range(16)) - 8);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_sample(input logic [SB-1:0] value);
		while (!steady && $urandom_range(99) < 28) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic apb_access(input logic write, input swm_pkg::swm_reg_t idx,
		input logic [swm_pkg::PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= swm_pkg::PADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input logic [LCW-1:0] len);
		logic [swm_pkg::PDATA_W-1:0] data;
		data = $urandom();
		data[LCW-1:0] = len;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, swm_pkg::REG_WINDOW_LENGTH, data);
		apb_access(1'b0, swm_pkg::REG_WINDOW_LENGTH, '0);
	endtask

	initial begin : stimulus
		logic [LCW-1:0] len;
		int             span;
		int             count;
		int             phase;
		int             random_sent;
		int             i;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset window length of one gives a result on every beat.
		apb_access(1'b0, swm_pkg::REG_WINDOW_LENGTH, '0);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);

		set_window(7'd2);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);

		// Duplicates in the window; a write to the spare address must not restart it.
		set_window(7'd3);
		send_sample(32'd5);
		send_sample(32'd5);
		send_sample(32'd5);
		send_sample(32'd7);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, swm_pkg::REG_UNUSED, $urandom());
		send_sample(32'd5);
		send_sample(32'd5);
		send_sample(-32'sd3);

		set_window(7'd0);
		send_sample(32'h1234_5678);
		send_sample(32'h8765_4321);

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: len = 7'd64;
				1: len = 7'd127;
				2: len = 7'd65;
				default: len = ($urandom_range(3) == 0) ? LCW'($urandom_range(127))
					: LCW'($urandom_range(1, 9));
			endcase
			set_window(len);
			span = (len == 0) ? 1 :
				((len > swm_pkg::WINDOW_MAX_DEF) ? swm_pkg::WINDOW_MAX_DEF : len);
			count = span + ((phase == 0) ? 180 : $urandom_range(8, 60));
			if (phase == 0)
				steady <= 1'b1;
			for (i = 0; i < count; i++) begin
				if (phase == 0 && i == 80)
					hold_requests <= hold_requests + 1;
				if (phase != 0 && i == count / 2 && $urandom_range(3) == 0)
					drain_results();
				send_sample(pick_sample());
			end
			steady <= 1'b0;
			random_sent += count;
			phase++;
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/swm_pkg.sv
rtl/swm_stream_if.sv
rtl/swm_cfg.sv
rtl/swm_cell.sv
rtl/sliding_window_median.sv
verif/swm_median_checker.sv
verif/tb_top.sv
